>>> rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants of the binding stack lookup
// Item layouts, operation and status codes, controller states and the
// control pair that moves down the cell chain.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int BSL_STACK_DEPTH = 64;
    localparam int BSL_KEY_WIDTH   = 16;
    localparam int BSL_VALUE_WIDTH = 64;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OVERFLOW    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [1:0] ST_BAD_RESTORE = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] symbol_key;
        logic [63:0] bind_value;
        logic [6:0]  restore_depth;
    } bsl_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [6:0]  current_depth;
    } bsl_rsp_t;

    // Search token control: active marks the token slot, found marks a hit.
    typedef struct packed {
        logic active;
        logic found;
    } bsl_tok_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } bsl_state_t;

endpackage

>>> rtl/binding_stack_lookup.sv
// ----------------------------------------------------------------------------
// binding_stack_lookup: key/value binding stack with shadowing
// Push, newest-first lookup and truncating restore over a chain of slots.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on request and raise start; it is taken at a rising edge
//   where start is high and busy is low. Each item gives exactly one result,
//   shown on result for one cycle with done high. The receiver cannot stall,
//   so results must be taken as they appear.
//   Push, restore and the unused operation code answer in the cycle after
//   the item is taken, and busy stays low, so one of them can be taken in
//   every cycle while no lookup is searching.
//   Lookup launches a search token into the top slot; it walks one slot per
//   cycle down the chain of STACK_DEPTH cells, oldest slot last, and the
//   first live slot with a matching key captures its value. The result
//   is registered once the token leaves the bottom cell; busy is high
//   while the token is in the chain, whose length alone sets the search time.
//   Reset clears the live count and all control state; slot contents are
//   left as they are and are only ever read below the live count, where a
//   push has written them.
// ----------------------------------------------------------------------------
module binding_stack_lookup
    import bsl_pkg::*;
#(
    parameter int STACK_DEPTH = BSL_STACK_DEPTH,
    parameter int KEY_WIDTH   = BSL_KEY_WIDTH,
    parameter int VALUE_WIDTH = BSL_VALUE_WIDTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bsl_req_t request,
    output logic     done,
    output bsl_rsp_t result
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    bsl_state_t state_reg;
    bsl_state_t state_next;

    logic [CNT_W-1:0] live_count_reg;
    logic [CNT_W-1:0] live_count_next;

    bsl_rsp_t result_reg;
    bsl_rsp_t result_next;
    logic     done_reg;
    logic     done_next;

    logic                   busy_int;
    logic                   accept;
    logic                   full;
    logic                   push_go;
    logic                   restore_ok;
    logic                   search_done;
    logic [KEY_WIDTH+15:0]  key_wide;
    logic [KEY_WIDTH-1:0]   key_in;
    logic [VALUE_WIDTH-1:0] value_in;
    logic [CMP_W-1:0]       target_cmp;
    logic [CMP_W-1:0]       count_cmp;
    logic [CNT_W+6:0]       depth_wide;
    logic [VALUE_WIDTH+63:0] found_wide;

    // Search token launched into the top cell on an accepted lookup.
    bsl_tok_t               launch_tok;

    bsl_tok_t               chain_tok   [STACK_DEPTH];
    logic [KEY_WIDTH-1:0]   chain_key   [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] chain_value [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] wr_sel;
    logic [STACK_DEPTH-1:0] live_bit;

    assign accept = start && !busy_int;

    // Keys wider than the input field are zero-extended, narrower ones cut.
    assign key_wide = {{KEY_WIDTH{1'b0}}, request.symbol_key};
    assign key_in   = key_wide[KEY_WIDTH-1:0];
    assign value_in = request.bind_value[VALUE_WIDTH-1:0];

    assign full    = (live_count_reg == CNT_W'(STACK_DEPTH));
    assign push_go = accept && (request.operation == OP_PUSH) && !full;

    assign target_cmp = CMP_W'(request.restore_depth);
    assign count_cmp  = CMP_W'(live_count_reg);
    assign restore_ok = (target_cmp <= count_cmp);

    always_comb
    begin
        launch_tok.active = accept && (request.operation == OP_LOOKUP);
        launch_tok.found  = 1'b0;
    end

    // Cell chain: slot i sits at cell i; the token enters at the top cell.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        assign wr_sel[i]   = push_go && (live_count_reg == CNT_W'(i));
        assign live_bit[i] = (CNT_W'(i) < live_count_reg);

        if (i == STACK_DEPTH - 1)
        begin : g_top
            bsl_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_sel[i]),
                .wr_key    (key_in),
                .wr_value  (value_in),
                .live      (live_bit[i]),
                .tok_in    (launch_tok),
                .key_in    (key_in),
                .value_in  ({VALUE_WIDTH{1'b0}}),
                .tok_out   (chain_tok[i]),
                .key_out   (chain_key[i]),
                .value_out (chain_value[i])
            );
        end
        else
        begin : g_mid
            bsl_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_sel[i]),
                .wr_key    (key_in),
                .wr_value  (value_in),
                .live      (live_bit[i]),
                .tok_in    (chain_tok[i+1]),
                .key_in    (chain_key[i+1]),
                .value_in  (chain_value[i+1]),
                .tok_out   (chain_tok[i]),
                .key_out   (chain_key[i]),
                .value_out (chain_value[i])
            );
        end
    end

    // The token leaving the bottom cell carries the lookup answer.
    assign search_done = (state_reg == S_SEARCH) && chain_tok[0].active;

    // Live count: advance on push, drop to the target on a valid restore.
    always_comb
    begin
        live_count_next = live_count_reg;
        if (push_go)
        begin
            live_count_next = live_count_reg + CNT_W'(1);
        end
        else if (accept && (request.operation == OP_RESTORE) && restore_ok)
        begin
            live_count_next = target_cmp[CNT_W-1:0];
        end
    end

    assign depth_wide = {7'd0, live_count_next};
    assign found_wide = {64'd0, chain_value[0]};

    // Result assembly for both the non-lookup operations and the search.
    always_comb
    begin
        done_next                 = 1'b0;
        result_next.status        = ST_OK;
        result_next.found_value   = '0;
        result_next.current_depth = depth_wide[6:0];
        if (search_done)
        begin
            done_next = 1'b1;
            if (chain_tok[0].found)
            begin
                result_next.found_value = found_wide[63:0];
            end
            else
            begin
                result_next.status = ST_NOT_FOUND;
            end
        end
        else if (accept && (request.operation != OP_LOOKUP))
        begin
            done_next = 1'b1;
            case (request.operation)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        result_next.status = ST_OVERFLOW;
                    end
                end
                OP_RESTORE:
                begin
                    if (!restore_ok)
                    begin
                        result_next.status = ST_BAD_RESTORE;
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
        end
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (launch_tok.active)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (chain_tok[0].active)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        case (state_reg)
            S_SEARCH: busy_int = 1'b1;
            default:  busy_int = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_int;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/bsl_cell.sv
// ----------------------------------------------------------------------------
// bsl_cell: one stack slot of the binding stack
// Holds one key/value binding and passes the search token one slot down,
// capturing the stored value on the first live match.
// ----------------------------------------------------------------------------
module bsl_cell
    import bsl_pkg::*;
#(
    parameter int KEY_WIDTH   = BSL_KEY_WIDTH,
    parameter int VALUE_WIDTH = BSL_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [KEY_WIDTH-1:0]   wr_key,
    input  logic [VALUE_WIDTH-1:0] wr_value,
    input  logic                   live,
    input  bsl_tok_t               tok_in,
    input  logic [KEY_WIDTH-1:0]   key_in,
    input  logic [VALUE_WIDTH-1:0] value_in,
    output bsl_tok_t               tok_out,
    output logic [KEY_WIDTH-1:0]   key_out,
    output logic [VALUE_WIDTH-1:0] value_out
);

    logic [KEY_WIDTH-1:0]   slot_key_reg;
    logic [VALUE_WIDTH-1:0] slot_value_reg;
    bsl_tok_t               tok_reg;
    bsl_tok_t               tok_next;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   hit;

    // Slot storage: written only by a push that targets this slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_key_reg   <= wr_key;
            slot_value_reg <= wr_value;
        end
    end

    assign hit = tok_in.active && !tok_in.found && live && (slot_key_reg == key_in);

    always_comb
    begin
        tok_next       = tok_in;
        value_next     = value_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            value_next     = slot_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_in;
        value_reg <= value_next;
    end

    assign tok_out   = tok_reg;
    assign key_out   = key_reg;
    assign value_out = value_reg;

endmodule

>>> rtl/bsl_checker.sv
// ----------------------------------------------------------------------------
// bsl_checker: port-level checks of the binding stack lookup
// Watches the command and result ports and flags ordering and value slips.
// ----------------------------------------------------------------------------
module bsl_checker
    import bsl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input bsl_req_t request,
    input logic     done,
    input bsl_rsp_t result
);

    // Push, restore and the unused code answer in the next cycle.
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation != OP_LOOKUP) |=> done)
        else $error("non-lookup item gave no result in the next cycle");

    // A lookup holds the command side off while it searches.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.operation == OP_LOOKUP) |=> (busy && !done))
        else $error("lookup did not hold busy");

    // Only a successful lookup returns a nonzero value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.found_value == 64'd0))
        else $error("failed operation returned a value");

    // Back-to-back results need an item taken in the first of them.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done || $past(start && !busy)))
        else $error("result without a matching item");

endmodule

bind binding_stack_lookup bsl_checker u_bsl_checker (.*);

>>> tb/sv/tb_binding_stack_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binding_stack_lookup: self-checking bench for the binding stack lookup
// Drives push, lookup, restore and unused-code items through the start/busy
// handshake with random gaps, predicts every answer with its own copy of the
// binding stack, and compares each done-marked result field by field, in order.
// ----------------------------------------------------------------------------
module tb_binding_stack_lookup;
    import bsl_pkg::*;

    localparam int          DEPTH        = BSL_STACK_DEPTH;
    localparam int          CLK_HALF     = 6;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          MAX_REPORTS  = 10;
    // Operation code 3 has no name in the package; the block ignores it.
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    bsl_req_t request = '0;
    logic     busy;
    logic     done;
    bsl_rsp_t result;

    binding_stack_lookup uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the binding stack. Only entries below live_bindings
    // are ever searched, and every one of those was written by a push.
    // ------------------------------------------------------------------
    logic [15:0] binding_keys [DEPTH];
    logic [63:0] binding_vals [DEPTH];
    int          live_bindings = 0;

    // Answers still owed by the block, oldest first.
    bsl_rsp_t    owed_answers [$];

    int error_count    = 0;
    int items_sent     = 0;
    int answers_seen   = 0;
    int n_push         = 0;
    int n_overflow     = 0;
    int n_lookup_hit   = 0;
    int n_lookup_miss  = 0;
    int n_restore      = 0;
    int n_bad_restore  = 0;
    int n_unused_op    = 0;

    // Idle between items only while this is set; cleared for whole bursts.
    bit          idle_on = 1'b1;
    // Small key pool so that lookups hit and bindings shadow each other.
    logic [15:0] key_pool [6];

    // Apply one operation to the shadow stack and return the answer it owes.
    function automatic bsl_rsp_t apply_binding_op(input bsl_req_t req);
        bsl_rsp_t rsp;
        rsp        = '0;
        rsp.status = ST_OK;
        case (req.operation)
            OP_PUSH:
            begin
                if (live_bindings < DEPTH)
                begin
                    binding_keys[live_bindings] = req.symbol_key;
                    binding_vals[live_bindings] = req.bind_value;
                    live_bindings++;
                    n_push++;
                end
                else
                begin
                    rsp.status = ST_OVERFLOW;
                    n_overflow++;
                end
            end
            OP_LOOKUP:
            begin
                rsp.status = ST_NOT_FOUND;
                // Newest binding wins: search from the top down.
                for (int i = live_bindings - 1; i >= 0; i--)
                begin
                    if (binding_keys[i] == req.symbol_key)
                    begin
                        rsp.found_value = binding_vals[i];
                        rsp.status      = ST_OK;
                        break;
                    end
                end
                if (rsp.status == ST_OK)
                    n_lookup_hit++;
                else
                    n_lookup_miss++;
            end
            OP_RESTORE:
            begin
                // Never grow the stack back: stale entries stay hidden.
                if (int'(req.restore_depth) > live_bindings)
                begin
                    rsp.status = ST_BAD_RESTORE;
                    n_bad_restore++;
                end
                else
                begin
                    live_bindings = int'(req.restore_depth);
                    n_restore++;
                end
            end
            default:
                n_unused_op++;
        endcase
        rsp.current_depth = 7'(live_bindings);
        return rsp;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int item_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [63:0] random_value();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Send one item: hold start high until the block takes it, then
    // predict its answer at the accepting edge.
    task automatic send_item(input logic [1:0] op, input logic [15:0] key,
                             input logic [63:0] val, input logic [6:0] depth);
        bsl_req_t req;
        int       gap;
        req.operation     = op;
        req.symbol_key    = key;
        req.bind_value    = val;
        req.restore_depth = depth;
        gap = item_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= req;
        start   <= 1'b1;
        // Busy sampled at the edge is the value the block decides on.
        do
            @(posedge clk);
        while (busy);
        owed_answers.push_back(apply_binding_op(req));
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done cycle must match the oldest owed answer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bsl_rsp_t want;
        if (done)
        begin
            answers_seen++;
            if (owed_answers.size() == 0)
                report_error($sformatf("result with nothing owed: status %0d value %h depth %0d",
                                       result.status, result.found_value,
                                       result.current_depth));
            else
            begin
                want = owed_answers.pop_front();
                if (result.status !== want.status)
                    report_error($sformatf("status: expected %0d, got %0d",
                                           want.status, result.status));
                if (result.found_value !== want.found_value)
                    report_error($sformatf("found_value: expected %h, got %h",
                                           want.found_value, result.found_value));
                if (result.current_depth !== want.current_depth)
                    report_error($sformatf("current_depth: expected %0d, got %0d",
                                           want.current_depth, result.current_depth));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty stack: miss, restore to zero, restore far above, unused code.
    task automatic test_empty_stack();
        send_item(OP_LOOKUP,  16'hFFFF, '0, '0);
        send_item(OP_LOOKUP,  16'h0000, '1, '1);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd0);
        send_item(OP_RESTORE, 16'hFFFF, '1, 7'd127);
        send_item(OP_UNUSED,  16'hFFFF, '1, 7'd127);
        send_item(OP_UNUSED,  16'h0000, '0, 7'd0);
    endtask

    // Shadowing, truncation and the stale entry that must stay hidden.
    task automatic test_shadow_and_restore();
        send_item(OP_PUSH,    16'h0000, 64'h0, 7'd0);
        send_item(OP_PUSH,    16'hFFFF, '1, 7'd127);
        send_item(OP_LOOKUP,  16'hFFFF, '0, 7'd0);
        send_item(OP_LOOKUP,  16'h0000, '1, 7'd0);
        send_item(OP_PUSH,    16'hFFFF, 64'hA5A5_5A5A_0F0F_F0F0, 7'd0);
        send_item(OP_LOOKUP,  16'hFFFF, '0, 7'd0);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd1);
        send_item(OP_LOOKUP,  16'hFFFF, '0, 7'd0);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd2);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd1);
        send_item(OP_LOOKUP,  16'h0000, '0, 7'd0);
        send_item(OP_UNUSED,  16'h0000, '0, 7'd0);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd0);
    endtask

    // Fill all slots with distinct keys, overflow, search to the bottom.
    task automatic test_fill_and_overflow();
        send_item(OP_RESTORE, 16'h0000, '0, 7'd0);
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_PUSH, 16'h1000 + 16'(i), random_value(), 7'd0);
        send_item(OP_PUSH,    16'hFFFF, '1, 7'd0);
        send_item(OP_PUSH,    16'h0000, '0, 7'd0);
        send_item(OP_LOOKUP,  16'h1000, '0, 7'd0);
        send_item(OP_LOOKUP,  16'h1000 + 16'(DEPTH - 1), '0, 7'd0);
        send_item(OP_LOOKUP,  16'hFFFF, '0, 7'd0);
        send_item(OP_RESTORE, 16'h0000, '0, 7'(DEPTH));
        send_item(OP_RESTORE, 16'h0000, '0, 7'(DEPTH + 1));
        send_item(OP_RESTORE, 16'h0000, '0, 7'd127);
        send_item(OP_RESTORE, 16'h0000, '0, 7'd0);
    endtask

    // Random bursts, each biased to grow, search or shrink the stack.
    task automatic test_random_sequences();
        int          burst;
        int          mode;
        int          roll;
        logic [1:0]  op;
        logic [15:0] key;
        logic [6:0]  depth;
        int          target;
        target = items_sent + RANDOM_ITEMS;
        foreach (key_pool[k])
            key_pool[k] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        while (items_sent < target)
        begin
            mode    = $urandom_range(0, 2);
            burst   = $urandom_range(8, 40);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (burst)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       op = (roll < 70) ? OP_PUSH : (roll < 90) ? OP_LOOKUP :
                                  (roll < 98) ? OP_RESTORE : OP_UNUSED;
                    1:       op = (roll < 25) ? OP_PUSH : (roll < 90) ? OP_LOOKUP :
                                  (roll < 98) ? OP_RESTORE : OP_UNUSED;
                    default: op = (roll < 20) ? OP_PUSH : (roll < 50) ? OP_LOOKUP :
                                  (roll < 95) ? OP_RESTORE : OP_UNUSED;
                endcase
                // Keys mostly from the pool, sometimes a live one or anything.
                roll = $urandom_range(0, 99);
                if (op == OP_LOOKUP && live_bindings > 0 && roll < 40)
                    key = binding_keys[$urandom_range(0, live_bindings - 1)];
                else if (roll < 85)
                    key = key_pool[$urandom_range(0, 5)];
                else
                    key = 16'($urandom);
                // Restore mostly within the live range, now and then above it.
                if ($urandom_range(0, 99) < 85)
                    depth = 7'($urandom_range(0, live_bindings));
                else
                    depth = 7'($urandom_range(live_bindings + 1, 127));
                send_item(op, key, random_value(), depth);
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_shadow_and_restore();
        test_fill_and_overflow();
        test_random_sequences();

        start <= 1'b0;
        // Drain: wait for every owed answer, then watch for stray results
        // across one full search.
        while (owed_answers.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Covered %0d items: %0d pushes, %0d overflows, %0d lookup hits, %0d misses,",
                 items_sent, n_push, n_overflow, n_lookup_hit, n_lookup_miss);
        $display("  %0d restores, %0d rejected restores, %0d unused codes; %0d errors.",
                 n_restore, n_bad_restore, n_unused_op, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: the slowest correct run is far below this.
    initial
    begin
        #(20_000_000);
        $display("Timeout: run did not complete, %0d answers still owed",
                 owed_answers.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
